[hdl/bpqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpqs_pkg
// Shared sizes, entry type, codes and circular slot arithmetic for the
// bounded priority queue.
// ----------------------------------------------------------------------------
package bpqs_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int TOTAL_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // Candidate handshake from the sequencer to the compare unit
    typedef struct packed {
        logic             load;
        logic             first;
        logic [IDX_W-1:0] off;
    } scan_ctrl_t;

    // Slot of the entry at a given offset from the head, wrapped at DEPTH
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH))
        begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[hdl/bounded_priority_queue_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_queue_scan
// Bounded priority queue of DEPTH entries with a linear-scan maximum search.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one item: an insert of
// (value, priority_req) or a removal of the highest-priority entry. Exactly
// one result follows per item, shown for a single cycle with done high; the
// receiver cannot stall, so capture it in that cycle. An insert passes from
// acceptance through the report state to done. For a removal the single
// store read port first walks the entries older than the removed one, one
// slot a cycle, to close the gap, then walks every remaining entry through
// the shared priority compare to find the new top. Removing the last entry
// skips the compare walk. An insert on a full queue or a removal on an empty
// one changes nothing. On equal priorities the entry inserted last is served
// first. busy is low again in the cycle that done is high.
// ----------------------------------------------------------------------------
module bounded_priority_queue_scan
    import bpqs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     op,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] priority_req,
    output logic                     busy,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] top_value,
    output logic                     top_valid,
    output logic [TOTAL_W-1:0]       entry_total
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SCAN,
        S_REPORT
    } state_t;

    state_t                   state_reg;
    logic [IDX_W-1:0]         head_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         k_reg;       // walk offset: shift source + 1, or scan read
    logic [IDX_W-1:0]         pipe_off_reg; // offset of the entry in rd_data
    logic                     pend_reg;    // rd_data holds a live entry
    logic                     done_reg;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] top_value_reg;
    logic                     top_valid_reg;
    logic [TOTAL_W-1:0]       entry_total_reg;

    logic             accept;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
    entry_t           rd_data;
    scan_ctrl_t       scan_ctrl;
    entry_t           scan_cand;
    entry_t           best;
    logic [IDX_W-1:0] best_off;

    assign accept = start && (state_reg == S_IDLE);

    bpqs_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    bpqs_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .cand     (scan_cand),
        .best     (best),
        .best_off (best_off)
    );

    // Store ports and compare candidate, steered by the sequencer state
    always_comb
    begin
        we              = 1'b0;
        waddr           = slot_of(head_reg, count_reg[IDX_W-1:0]);
        wdata.value     = value;
        wdata.prio      = priority_req;
        raddr           = slot_of(head_reg, k_reg);
        scan_ctrl.load  = 1'b0;
        scan_ctrl.first = 1'b0;
        scan_ctrl.off   = pipe_off_reg;
        scan_cand       = rd_data;
        case (state_reg)
            S_IDLE:
            begin
                // Append at the tail and offer the new entry to the compare
                if (accept && (op == OP_INSERT) && (count_reg < CNT_W'(DEPTH)))
                begin
                    we              = 1'b1;
                    scan_ctrl.load  = 1'b1;
                    scan_ctrl.first = (count_reg == '0);
                    scan_ctrl.off   = count_reg[IDX_W-1:0];
                    scan_cand       = wdata;
                end
            end
            S_SHIFT:
            begin
                // Read slot k-1, write it one slot toward the tail next cycle
                raddr = slot_of(head_reg, k_reg - IDX_W'(1));
                we    = pend_reg;
                waddr = slot_of(head_reg, pipe_off_reg);
                wdata = rd_data;
            end
            S_SCAN:
            begin
                scan_ctrl.load  = pend_reg;
                scan_ctrl.first = (pipe_off_reg == '0);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            k_reg           <= '0;
            pipe_off_reg    <= '0;
            pend_reg        <= 1'b0;
            done_reg        <= 1'b0;
            status_reg      <= ST_DONE;
            top_valid_reg   <= 1'b0;
            entry_total_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= ST_DONE;
                        state_reg  <= S_REPORT;
                        if (op == OP_INSERT)
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            status_reg <= ST_EMPTY;
                        end
                        else
                        begin
                            // Start closing the gap at the current top
                            k_reg     <= best_off;
                            pend_reg  <= 1'b0;
                            state_reg <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT:
                begin
                    if (k_reg != '0)
                    begin
                        k_reg        <= k_reg - IDX_W'(1);
                        pipe_off_reg <= k_reg;
                        pend_reg     <= 1'b1;
                    end
                    else
                    begin
                        // Last move lands this cycle; drop the oldest slot
                        pend_reg  <= 1'b0;
                        count_reg <= count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            head_reg  <= '0;
                            state_reg <= S_REPORT;
                        end
                        else
                        begin
                            head_reg  <= slot_of(head_reg, IDX_W'(1));
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (CNT_W'(k_reg) < count_reg)
                    begin
                        k_reg        <= k_reg + IDX_W'(1);
                        pipe_off_reg <= k_reg;
                        pend_reg     <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && (CNT_W'(k_reg) == count_reg))
                    begin
                        k_reg     <= '0;
                        state_reg <= S_REPORT;
                    end
                end
                S_REPORT:
                begin
                    done_reg        <= 1'b1;
                    top_valid_reg   <= (count_reg != '0);
                    entry_total_reg <= TOTAL_W'(count_reg);
                    state_reg       <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the reported top value; zero when the queue is empty
    always_ff @(posedge clk)
    begin
        if (state_reg == S_REPORT)
        begin
            top_value_reg <= (count_reg != '0) ? best.value : '0;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign top_value   = top_value_reg;
    assign top_valid   = top_valid_reg;
    assign entry_total = entry_total_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while sequencer still busy");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_EMPTY)) |-> (!top_valid_reg && (count_reg == '0)))
        else $error("empty removal reported with entries held");
`endif

endmodule

[hdl/bpqs_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpqs_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bpqs_store
    import bpqs_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/bpqs_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpqs_scan
// Shared signed priority compare; holds the best entry seen and its offset.
// ----------------------------------------------------------------------------
module bpqs_scan
    import bpqs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctrl_t       ctrl,
    input  entry_t           cand,
    output entry_t           best,
    output logic [IDX_W-1:0] best_off
);

    entry_t           best_reg;
    logic [IDX_W-1:0] best_off_reg;
    logic             take;

    // Later candidates win ties
    assign take = ctrl.load && (ctrl.first || (cand.prio >= best_reg.prio));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_off_reg <= '0;
        end
        else if (take)
        begin
            best_off_reg <= ctrl.off;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg <= cand;
        end
    end

    assign best     = best_reg;
    assign best_off = best_off_reg;

endmodule

[bench/tb_bounded_priority_queue_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_priority_queue_scan
// Self-checking bench for the linear-scan bounded priority queue. Inserts and
// removals are driven through the start/busy handshake. A scoreboard keeps its
// own copy of the circular store and works out the status, top entry and count
// expected after every accepted item. It compares each done strobe with the
// oldest expected report.
// ----------------------------------------------------------------------------
module tb_bounded_priority_queue_scan;

    import bpqs_pkg::*;

    // Everything the block reports for one item
    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] top_value;
        logic                     top_valid;
        logic [TOTAL_W-1:0]       total;
    } queue_report_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow of the queue plus the reports still owed by the
    // block, oldest first.
    // ------------------------------------------------------------------------
    class top_entry_scoreboard;
        logic signed [DATA_W-1:0] slot_value [DEPTH];
        logic signed [DATA_W-1:0] slot_prio  [DEPTH];
        int unsigned              head;
        int unsigned              held;
        queue_report_t            owed_reports [$];
        int unsigned              fault_count;

        function new();
            head        = 0;
            held        = 0;
            fault_count = 0;
        endfunction

        function int unsigned slot_at(int unsigned off);
            return (head + off) % DEPTH;
        endfunction

        // Offset from the oldest entry of the highest priority; on a tie the
        // later entry takes over, so compare with >=
        function int unsigned winner_offset();
            int unsigned best;
            best = 0;
            for (int unsigned k = 1; k < held; k++)
            begin
                if (slot_prio[slot_at(k)] >= slot_prio[slot_at(best)])
                begin
                    best = k;
                end
            end
            return best;
        endfunction

        function void note_fault(string msg);
            fault_count++;
            if (fault_count <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        // Apply one accepted item to the shadow queue and owe its report
        function void apply_command(logic cmd, logic signed [DATA_W-1:0] val,
                                    logic signed [DATA_W-1:0] pri);
            queue_report_t rep;
            int unsigned   j;
            rep.status = ST_DONE;
            if (cmd == OP_INSERT)
            begin
                if (held >= DEPTH)
                begin
                    rep.status = ST_FULL;
                end
                else
                begin
                    slot_value[slot_at(held)] = val;
                    slot_prio[slot_at(held)]  = pri;
                    held++;
                end
            end
            else if (held == 0)
            begin
                rep.status = ST_EMPTY;
            end
            else
            begin
                // Slide the older entries over the removed one, then drop the head
                j = winner_offset();
                while (j > 0)
                begin
                    slot_value[slot_at(j)] = slot_value[slot_at(j - 1)];
                    slot_prio[slot_at(j)]  = slot_prio[slot_at(j - 1)];
                    j--;
                end
                head = (head + 1) % DEPTH;
                held--;
                if (held == 0)
                begin
                    head = 0;
                end
            end
            if (held > 0)
            begin
                rep.top_value = slot_value[slot_at(winner_offset())];
                rep.top_valid = 1'b1;
            end
            else
            begin
                rep.top_value = '0;
                rep.top_valid = 1'b0;
            end
            rep.total = TOTAL_W'(held);
            owed_reports.push_back(rep);
        endfunction

        function void compare_report(logic [1:0] st, logic signed [DATA_W-1:0] tv,
                                     logic vld, logic [TOTAL_W-1:0] tot);
            queue_report_t want;
            if (owed_reports.size() == 0)
            begin
                note_fault($sformatf("unexpected result: status=%0d top=%0d valid=%0b total=%0d",
                                     st, tv, vld, tot));
                return;
            end
            want = owed_reports.pop_front();
            if (st !== want.status || tv !== want.top_value || vld !== want.top_valid ||
                tot !== want.total)
            begin
                note_fault($sformatf({"mismatch: status %0d/%0d top %0d/%0d valid %0b/%0b",
                                      " total %0d/%0d (expected/actual)"},
                                     want.status, st, want.top_value, tv,
                                     want.top_valid, vld, want.total, tot));
            end
        endfunction

        function int unsigned pending();
            return owed_reports.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     start        = 1'b0;
    logic                     op           = OP_INSERT;
    logic signed [DATA_W-1:0] value        = '0;
    logic signed [DATA_W-1:0] priority_req = '0;
    logic                     busy;
    logic                     done;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] top_value;
    logic                     top_valid;
    logic [TOTAL_W-1:0]       entry_total;

    top_entry_scoreboard queue_board;
    bit                  gaps_on = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bounded_priority_queue_scan u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .value        (value),
        .priority_req (priority_req),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .top_value    (top_value),
        .top_valid    (top_valid),
        .entry_total  (entry_total)
    );

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge. A result strobe belongs to an item
    // already owed, so check it before noting an item accepted at this edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                queue_board.compare_report(status, top_value, top_valid, entry_total);
            end
            if (start && !busy)
            begin
                queue_board.apply_command(op, value, priority_req);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Optionally hold start low
    // for a while, then raise it with the item and wait until the block
    // takes it. Start stays high into the next call, so back-to-back items
    // never see it dropped and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_command(logic cmd, logic signed [DATA_W-1:0] val,
                                logic signed [DATA_W-1:0] pri);
        int unsigned gap;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 99) < 17)
        begin
            // Mostly short pauses, now and then one that spans a whole removal
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        op           <= cmd;
        value        <= val;
        priority_req <= pri;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
    endtask

    // Priority drawn to hit ties, extremes and the full range alike
    function automatic logic signed [DATA_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return $signed(32'($urandom_range(0, 6))) - 3;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned insert_pct;
        int unsigned seg_left;
        logic        cmd;

        queue_board = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: remove on empty, extremes of value and priority, a tie on
        // the top priority, fill to the brim, overfill, then drain part way
        // so the random part starts with a wrapped head
        send_command(OP_REMOVE, 32'sh0, 32'sh0);
        send_command(OP_INSERT, 32'sh7fff_ffff, 32'sh0);
        send_command(OP_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
        send_command(OP_INSERT, 32'sh0, 32'sh8000_0000);
        send_command(OP_INSERT, -32'sd1, 32'sh7fff_ffff);
        send_command(OP_INSERT, 32'sh5555_aaaa, -32'sd1);
        for (int i = 0; i < 11; i++)
        begin
            send_command(OP_INSERT, $urandom, pick_priority());
        end
        send_command(OP_INSERT, 32'sh1234_5678, 32'sh7fff_ffff);
        for (int i = 0; i < 6; i++)
        begin
            send_command(OP_REMOVE, $urandom, $urandom);
        end

        // Random: segments leaning towards filling or draining, so the count
        // sweeps between empty and full and the head wraps many times over.
        // A middle stretch runs with no pauses at all.
        seg_left = 0;
        for (int i = 0; i < 1925; i++)
        begin
            if (seg_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: insert_pct = 25;
                    1: insert_pct = 50;
                    2: insert_pct = 75;
                    default: insert_pct = 90;
                endcase
                seg_left = $urandom_range(20, 60);
            end
            seg_left--;
            gaps_on = !(i >= 700 && i < 1000);
            cmd = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            send_command(cmd, $urandom, pick_priority());
        end

        @(negedge clk);
        start <= 1'b0;

        // Drain what is owed, then watch a while longer for stray strobes
        while (queue_board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        if (queue_board.fault_count == 0 && queue_board.pending() == 0)
        begin
            $display("tb_bounded_priority_queue_scan OK");
        end
        else
        begin
            $display("tb_bounded_priority_queue_scan NOT OK");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb_bounded_priority_queue_scan NOT OK");
        $finish;
    end

endmodule

[bounded_priority_queue_scan.f]
hdl/bpqs_pkg.sv
hdl/bpqs_store.sv
hdl/bpqs_scan.sv
hdl/bounded_priority_queue_scan.sv
bench/tb_bounded_priority_queue_scan.sv
